// ----- src/v3n_pkg.sv -----
// Package for the 3-D vector normalizer: widths, pipeline depths and shared types.
// Used by every module in src; depends on nothing.
`default_nettype none
package v3n_pkg;
   localparam int CompWidth = 24;
   localparam int UnitFrac  = CompWidth - 2;
   localparam int MagWidth  = CompWidth;
   localparam int SumWidth  = 2 * CompWidth + 2;
   localparam int SqrtSteps = MagWidth;
   localparam int DivSteps  = UnitFrac + 2;
   localparam int QuotWidth = UnitFrac + 2;
   localparam int DivNum    = CompWidth + UnitFrac;

   typedef logic signed [CompWidth-1:0] comp_type;
   typedef logic [MagWidth-1:0] mag_type;

   typedef struct packed {
      logic             valid;
      logic [2:0]       neg;
      logic [CompWidth-1:0] ax;
      logic [CompWidth-1:0] ay;
      logic [CompWidth-1:0] az;
   } abs_type;
endpackage
`default_nettype wire

// ----- src/v3n_sqsum.sv -----
// Squares the component magnitudes and adds them; three register stages.
// Depends on v3n_pkg.
`default_nettype none
module v3n_sqsum (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire v3n_pkg::comp_type          in_x,
   input  wire v3n_pkg::comp_type          in_y,
   input  wire v3n_pkg::comp_type          in_z,
   output v3n_pkg::abs_type                out_abs,
   output logic [v3n_pkg::SumWidth-1:0]    out_sum
);
   import v3n_pkg::*;

   abs_type a_ff, a_in, b_ff;
   logic [2*CompWidth-1:0] sq_ff [3];
   logic [SumWidth-1:0] sum_ff;

   function automatic logic [CompWidth-1:0] mag_of(input comp_type v);
      mag_of = v[CompWidth-1] ? CompWidth'(-v) : CompWidth'(v);
   endfunction

   always_comb begin
      a_in.valid = in_valid;
      a_in.neg   = {in_z[CompWidth-1], in_y[CompWidth-1], in_x[CompWidth-1]};
      a_in.ax    = mag_of(in_x);
      a_in.ay    = mag_of(in_y);
      a_in.az    = mag_of(in_z);
   end

   always_ff @(posedge clock) begin
      sq_ff[0] <= a_ff.ax * a_ff.ax;
      sq_ff[1] <= a_ff.ay * a_ff.ay;
      sq_ff[2] <= a_ff.az * a_ff.az;
      sum_ff <= SumWidth'(sq_ff[0]) + SumWidth'(sq_ff[1]) + SumWidth'(sq_ff[2]);
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= a_ff;
      end
   end

   abs_type c_ff;
   always_ff @(posedge clock) begin
      if (reset) c_ff <= '0;
      else c_ff <= b_ff;
   end

   assign out_abs = c_ff;
   assign out_sum = sum_ff;
endmodule
`default_nettype wire

// ----- src/v3n_sqrt.sv -----
// Pipelined restoring square root, one result bit per stage.
// Depends on v3n_pkg; carries the component magnitudes alongside.
`default_nettype none
module v3n_sqrt (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire v3n_pkg::abs_type        in_abs,
   input  wire logic [v3n_pkg::SumWidth-1:0] in_sum,
   output v3n_pkg::abs_type             out_abs,
   output v3n_pkg::mag_type             out_mag
);
   import v3n_pkg::*;

   abs_type              abs_ff  [SqrtSteps+1];
   logic [SumWidth-1:0]  rem_ff  [SqrtSteps+1];
   logic [MagWidth-1:0]  root_ff [SqrtSteps+1];

   always_comb begin
      abs_ff[0]  = in_abs;
      rem_ff[0]  = in_sum;
      root_ff[0] = '0;
   end

   // Stage k decides root bit MagWidth-1-k against a trial of 4*root+1 at that weight.
   for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
      localparam int Sh = 2 * (MagWidth - 1 - k);
      logic [SumWidth-1:0] trial;
      logic [SumWidth-1:0] part;
      always_comb begin
         part  = rem_ff[k] >> Sh;
         trial = (SumWidth'(root_ff[k]) << 2) | SumWidth'(1);
      end
      always_ff @(posedge clock) begin
         if (reset) abs_ff[k+1] <= '0;
         else abs_ff[k+1] <= abs_ff[k];
         if (part >= trial) begin
            rem_ff[k+1]  <= rem_ff[k] - (trial << Sh);
            root_ff[k+1] <= {root_ff[k][MagWidth-2:0], 1'b1};
         end else begin
            rem_ff[k+1]  <= rem_ff[k];
            root_ff[k+1] <= {root_ff[k][MagWidth-2:0], 1'b0};
         end
      end
   end

   assign out_abs = abs_ff[SqrtSteps];
   assign out_mag = root_ff[SqrtSteps];
endmodule
`default_nettype wire

// ----- src/v3n_div.sv -----
// Pipelined restoring divider for three components by one shared length.
// Depends on v3n_pkg.
`default_nettype none
module v3n_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire v3n_pkg::abs_type  in_abs,
   input  wire v3n_pkg::mag_type  in_mag,
   output logic                   out_valid,
   output v3n_pkg::comp_type      out_x,
   output v3n_pkg::comp_type      out_y,
   output v3n_pkg::comp_type      out_z,
   output v3n_pkg::mag_type       out_mag,
   output logic                   out_zero
);
   import v3n_pkg::*;

   localparam int RemWidth = MagWidth + 1;

   logic                 vld_ff [DivSteps+1];
   logic [2:0]           neg_ff [DivSteps+1];
   mag_type              mag_ff [DivSteps+1];
   logic [DivNum-1:0]    num_ff [DivSteps+1][3];
   logic [RemWidth-1:0]  rem_ff [DivSteps+1][3];
   logic [QuotWidth-1:0] quo_ff [DivSteps+1][3];

   always_comb begin
      vld_ff[0] = in_abs.valid;
      neg_ff[0] = in_abs.neg;
      mag_ff[0] = in_mag;
      num_ff[0][0] = DivNum'(in_abs.ax) << UnitFrac;
      num_ff[0][1] = DivNum'(in_abs.ay) << UnitFrac;
      num_ff[0][2] = DivNum'(in_abs.az) << UnitFrac;
      for (int i = 0; i < 3; i++) begin
         // The quotient is at most 2^UnitFrac, so the leading numerator bits give
         // the starting remainder directly (they are below the length).
         rem_ff[0][i] = RemWidth'(num_ff[0][i] >> (QuotWidth));
         quo_ff[0][i] = '0;
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [RemWidth-1:0] sh [3];
      always_comb begin
         for (int i = 0; i < 3; i++)
            sh[i] = {rem_ff[k][i][RemWidth-2:0], num_ff[k][i][QuotWidth-1-k]};
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else vld_ff[k+1] <= vld_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         mag_ff[k+1] <= mag_ff[k];
         for (int i = 0; i < 3; i++) begin
            num_ff[k+1][i] <= num_ff[k][i];
            if (sh[i] >= RemWidth'(mag_ff[k]) && mag_ff[k] != '0) begin
               rem_ff[k+1][i] <= sh[i] - RemWidth'(mag_ff[k]);
               quo_ff[k+1][i] <= {quo_ff[k][i][QuotWidth-2:0], 1'b1};
            end else begin
               rem_ff[k+1][i] <= sh[i];
               quo_ff[k+1][i] <= {quo_ff[k][i][QuotWidth-2:0], 1'b0};
            end
         end
      end
   end

   logic     vo_ff, zo_ff;
   comp_type xo_ff, yo_ff, zc_ff;
   mag_type  mo_ff;

   function automatic comp_type signed_q(input logic [QuotWidth-1:0] q, input logic n);
      signed_q = n ? CompWidth'(-{1'b0, q}) : CompWidth'({1'b0, q});
   endfunction

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= vld_ff[DivSteps];
      zo_ff <= (mag_ff[DivSteps] == '0);
      mo_ff <= mag_ff[DivSteps];
      xo_ff <= signed_q(quo_ff[DivSteps][0], neg_ff[DivSteps][0]);
      yo_ff <= signed_q(quo_ff[DivSteps][1], neg_ff[DivSteps][1]);
      zc_ff <= signed_q(quo_ff[DivSteps][2], neg_ff[DivSteps][2]);
   end

   assign out_valid = vo_ff;
   assign out_zero  = zo_ff;
   assign out_mag   = mo_ff;
   assign out_x     = xo_ff;
   assign out_y     = yo_ff;
   assign out_z     = zc_ff;

`ifndef ASSERT_OFF
   a_zero_outputs: assert property (@(posedge clock) disable iff (reset)
      vo_ff && zo_ff |-> xo_ff == '0 && yo_ff == '0 && zc_ff == '0)
      else $error("zero vector gave nonzero unit components");
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> $signed(xo_ff) <= $signed(CompWidth'(1 << UnitFrac))
             && $signed(xo_ff) >= -$signed(CompWidth'(1 << UnitFrac)))
      else $error("unit x outside unit range");
   a_axis_exact: assert property (@(posedge clock) disable iff (reset)
      vo_ff && !zo_ff && yo_ff == '0 && zc_ff == '0 |-> xo_ff != '0)
      else $error("nonzero length gave all-zero components");
`endif
endmodule
`default_nettype wire

// ----- src/vec3_normalize_unit.sv -----
// Top level of the 3-D vector normalizer: squares, square root and divide pipelines.
// Depends on v3n_pkg, v3n_sqsum, v3n_sqrt and v3n_div.
//
//  channel   handshake           payload
//  request   start / busy        req_vec_x, req_vec_y, req_vec_z
//  response  rsp_valid strobe    rsp_unit_x/y/z, rsp_magnitude, rsp_zero_vector
//
// One request per cycle; busy is always low. A request passes through the squaring
// stages, the bit-per-stage square root and divider pipelines and an output register.
// Synchronous reset clears the valid bits and the squaring and root stage records.
// The receiver takes each response in its strobe cycle and cannot stall.
`default_nettype none
module vec3_normalize_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire v3n_pkg::comp_type req_vec_x,
   input  wire v3n_pkg::comp_type req_vec_y,
   input  wire v3n_pkg::comp_type req_vec_z,
   output logic                   rsp_valid,
   output v3n_pkg::comp_type      rsp_unit_x,
   output v3n_pkg::comp_type      rsp_unit_y,
   output v3n_pkg::comp_type      rsp_unit_z,
   output v3n_pkg::mag_type       rsp_magnitude,
   output logic                   rsp_zero_vector
);
   import v3n_pkg::*;

   abs_type             sq_abs, rt_abs;
   logic [SumWidth-1:0] sq_sum;
   mag_type             rt_mag;

   assign busy = 1'b0;

   v3n_sqsum u_sqsum (
      .clock, .reset, .in_valid(start && !busy),
      .in_x(req_vec_x), .in_y(req_vec_y), .in_z(req_vec_z),
      .out_abs(sq_abs), .out_sum(sq_sum)
   );

   v3n_sqrt u_sqrt (
      .clock, .reset, .in_abs(sq_abs), .in_sum(sq_sum),
      .out_abs(rt_abs), .out_mag(rt_mag)
   );

   v3n_div u_div (
      .clock, .reset, .in_abs(rt_abs), .in_mag(rt_mag),
      .out_valid(rsp_valid), .out_x(rsp_unit_x), .out_y(rsp_unit_y),
      .out_z(rsp_unit_z), .out_mag(rsp_magnitude), .out_zero(rsp_zero_vector)
   );
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for vec3_normalize_unit: sends vectors, predicts length and unit components.
// Depends on v3n_pkg and the RTL in src.
`timescale 1ns / 1ps
module tb;
   import v3n_pkg::*;

   typedef struct {
      logic [23:0] ux;
      logic [23:0] uy;
      logic [23:0] uz;
      logic [23:0] mag;
      logic        zero;
   } unit_vec_type;

   logic     clock = 0;
   logic     reset = 1;
   logic     start = 0;
   logic     busy;
   comp_type req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic     rsp_valid;
   comp_type rsp_unit_x, rsp_unit_y, rsp_unit_z;
   mag_type  rsp_magnitude;
   logic     rsp_zero_vector;

   unit_vec_type pending_units[$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        allow_gaps = 1;

   vec3_normalize_unit dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] s);
      logic [63:0] root;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= s)
            root = root | (64'd1 << b);
      end
      return root;
   endfunction

   function automatic logic [23:0] scaled_quotient(longint c, longint mag);
      longint q;
      q = ((c < 0 ? -c : c) <<< 22) / mag;
      if (c < 0)
         q = -q;
      return q[23:0];
   endfunction

   function automatic unit_vec_type normalize(comp_type x, comp_type y, comp_type z);
      unit_vec_type r;
      longint    lx, ly, lz, m;
      lx = x;
      ly = y;
      lz = z;
      m = longint'(floor_sqrt(lx * lx + ly * ly + lz * lz));
      r.mag = m[23:0];
      r.zero = (m == 0);
      if (m == 0) begin
         r.ux = 0;
         r.uy = 0;
         r.uz = 0;
      end else begin
         r.ux = scaled_quotient(lx, m);
         r.uy = scaled_quotient(ly, m);
         r.uz = scaled_quotient(lz, m);
      end
      return r;
   endfunction

   // A request is accepted at the rising edge where start is high and busy low.
   task automatic send_vector(comp_type x, comp_type y, comp_type z);
      if (allow_gaps && $urandom_range(0, 5) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      start <= 1;
      req_vec_x <= x;
      req_vec_y <= y;
      req_vec_z <= z;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_units.push_back(normalize(x, y, z));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      unit_vec_type e;
      if (!reset && rsp_valid) begin
         if (pending_units.size() == 0) begin
            $error("unexpected response");
            error_count++;
         end else begin
            e = pending_units.pop_front();
            if (rsp_unit_x !== e.ux) begin
               $error("unit_x expected %h actual %h", e.ux, rsp_unit_x);
               error_count++;
            end
            if (rsp_unit_y !== e.uy) begin
               $error("unit_y expected %h actual %h", e.uy, rsp_unit_y);
               error_count++;
            end
            if (rsp_unit_z !== e.uz) begin
               $error("unit_z expected %h actual %h", e.uz, rsp_unit_z);
               error_count++;
            end
            if (rsp_magnitude !== e.mag) begin
               $error("magnitude expected %h actual %h", e.mag, rsp_magnitude);
               error_count++;
            end
            if (rsp_zero_vector !== e.zero) begin
               $error("zero_vector expected %b actual %b", e.zero, rsp_zero_vector);
               error_count++;
            end
         end
      end
   end

   task automatic test_corner_vectors();
      comp_type vmax, vmin;
      vmax = 24'h7fffff;
      vmin = 24'h800000;
      send_vector('0, '0, '0);
      send_vector(24'sd1, 24'sd1, 24'sd1);
      send_vector(24'sd1, '0, '0);
      send_vector('0, -24'sd1, '0);
      send_vector('0, '0, vmin);
      send_vector(vmax, '0, '0);
      send_vector(vmax, vmax, vmax);
      send_vector(vmin, vmin, vmin);
      send_vector(vmin, vmax, vmin);
      send_vector(24'h010000, 24'h010000, '0);
      send_vector(-24'sd3, 24'sd4, '0);
      send_vector(24'h555555, 24'haaaaaa, 24'h0f0f0f);
      send_vector('0, '0, '0);
   endtask

   // Mixes full-range vectors with short ones so tiny lengths are exercised.
   task automatic test_random_vectors(int count);
      comp_type v[3];
      for (int i = 0; i < count; i++) begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 3))
               0: v[k] = comp_type'($urandom);
               1: v[k] = comp_type'($signed($urandom_range(0, 15)) - 8);
               2: v[k] = comp_type'($signed($urandom_range(0, 4095)) - 2048);
               default: v[k] = ($urandom_range(0, 7) == 0) ? '0 : comp_type'($urandom);
            endcase
         end
         send_vector(v[0], v[1], v[2]);
      end
   endtask

   task automatic test_back_to_back(int count);
      allow_gaps = 0;
      test_random_vectors(count);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_corner_vectors();
      test_random_vectors(900);
      test_back_to_back(250);
      start <= 0;
      while (pending_units.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
